// File: sv/edd_pkg.sv
// Shared sizes, register indexes and fixed-point constants of the error diffusion dither.
package edd_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int FILL_W       = COL_W + 1;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int SPAN_W       = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
    localparam int LEVEL_W      = 8;
    localparam int ERR_W        = 16;
    localparam int SUM_W        = 18;
    localparam int WIDE_W       = 20;

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // rows narrower than this wait for the pipe to drain before the next pixel
    localparam int MIN_PIPE_WIDTH = 4;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 16'd480;

    localparam logic signed [SUM_W-1:0] HALF_LEVEL  = 18'sd2040;
    localparam logic signed [SUM_W-1:0] WHITE_LEVEL = 18'sd4080;

    localparam logic [2:0] SHARE_RIGHT       = 3'd7;
    localparam logic [2:0] SHARE_BELOW       = 3'd5;
    localparam logic [2:0] SHARE_BELOW_LEFT  = 3'd3;
    localparam logic [2:0] SHARE_BELOW_RIGHT = 3'd1;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

// File: sv/edd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port, read-first.
module edd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/error_diffusion_dither.sv
// Floyd-Steinberg error diffusion dither: 8-bit gray in, one dot out, two line-store banks.
//
//  channel   direction  handshake           payload
//  pixel     in         i_valid / o_stall   i_pixel_level[7:0]
//  dot       out        o_valid / i_stall   o_dot, o_row_end, o_frame_end
//  config    in         APB psel/penable    paddr[2:0], pwdata, prdata (0: width, 4: height)
//
// One pixel per cycle at an effective width of 4 or more unless the dot side stalls; a
// pixel reaches o_valid through the stage 1 and stage 2 registers. The right-carry loop
// (sum, threshold, 7/16 share) closes combinationally in stage 1. Narrower rows re-read
// entries still in flight, so a pixel waits for the pipe to empty. Reset is synchronous;
// no clearing pass, a fill count makes line-store entries not yet written read as zero.
// A stall on the dot side freezes the whole pipe and the RAM read registers.
module error_diffusion_dither (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [edd_pkg::LEVEL_W-1:0]       i_pixel_level,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_dot,
    output logic                              o_row_end,
    output logic                              o_frame_end,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [edd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [edd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [edd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import edd_pkg::*;

    function automatic logic signed [ERR_W-1:0] f_sat16(input logic signed [WIDE_W-1:0] v);
        logic signed [ERR_W-1:0] res;
        if (v > 20'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[ERR_W-1:0];
        end
        return res;
    endfunction

    // floor((e*k + 8) / 16)
    function automatic logic signed [ERR_W-1:0] f_share(input logic signed [ERR_W-1:0] e,
                                                        input logic [2:0] k);
        logic signed [WIDE_W-1:0] p;
        p = WIDE_W'(e) * $signed({17'd0, k}) + 20'sd8;
        return p[WIDE_W-1:4];
    endfunction

    // configuration
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    t_reg_idx                w_reg_idx;

    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                REG_IMAGE_WIDTH:  r_width  <= pwdata[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // frame geometry
    logic [SPAN_W-1:0]       w_width_ext;
    logic [SPAN_W-1:0]       w_span;
    logic [HEIGHT_REG_W-1:0] w_rows;
    logic                    w_small;

    always_comb begin
        w_width_ext = SPAN_W'(r_width);
        if (w_width_ext == '0) begin
            w_span = SPAN_W'(1);
        end else if (w_width_ext > SPAN_W'(MAX_WIDTH)) begin
            w_span = SPAN_W'(MAX_WIDTH);
        end else begin
            w_span = w_width_ext;
        end
        w_rows  = (r_height == '0) ? HEIGHT_REG_W'(1) : r_height;
        w_small = w_span < SPAN_W'(MIN_PIPE_WIDTH);
    end

    // position
    logic [COL_W-1:0]        r_col,  n_col;
    logic [HEIGHT_REG_W-1:0] r_row,  n_row;
    logic                    r_bank, n_bank;
    logic                    w_last_col, w_last_row;

    // pipeline control
    logic r_s1_v, r_s2_v;
    logic w_adv, w_accept, w_wr;

    assign w_adv    = !(r_s2_v && i_stall);
    assign o_stall  = !w_adv || (w_small && (r_s1_v || r_s2_v));
    assign w_accept = i_valid && !o_stall;
    assign w_wr     = r_s2_v && !i_stall;

    always_comb begin
        w_last_col = (SPAN_W'(r_col) + SPAN_W'(1)) >= w_span;
        w_last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, w_rows};
        n_col  = r_col;
        n_row  = r_row;
        n_bank = r_bank;
        if (w_accept) begin
            if (w_last_col) begin
                n_col  = '0;
                n_bank = !r_bank;
                n_row  = w_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col  = r_col + 1'b1;
            end
        end
    end

    // line stores and fill count
    logic [FILL_W-1:0]       r_fill;
    logic                    w_filled;
    logic [COL_W-1:0]        w_wr_addr;
    logic [ERR_W-1:0]        w_wdata0, w_wdata1;
    logic [ERR_W-1:0]        w_rdata0, w_rdata1;

    assign w_filled = FILL_W'(r_col) < r_fill;

    edd_ram #(.WIDTH(ERR_W), .DEPTH(MAX_WIDTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wdata0),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_rdata0)
    );

    edd_ram #(.WIDTH(ERR_W), .DEPTH(MAX_WIDTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wdata1),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_rdata1)
    );

    // stage 1: threshold and right carry
    logic [LEVEL_W-1:0]        r_s1_level;
    logic [COL_W-1:0]          r_s1_col;
    logic                      r_s1_bank, r_s1_last_col, r_s1_last_row, r_s1_filled;
    logic signed [ERR_W-1:0]   r_rc;

    // stage 2 / output
    logic                      r_s2_white, r_s2_bank, r_s2_last_col, r_s2_last_row;
    logic signed [ERR_W-1:0]   r_s2_err, r_s2_old;
    logic [COL_W-1:0]          r_s2_col;

    // below-row accumulation state
    logic signed [ERR_W-1:0]   r_acc, r_b1;
    logic [COL_W-1:0]          r_last;

    logic signed [ERR_W-1:0]   w_in_rd, w_nx_rd, w_carried, w_old;
    logic                      w_fwd, w_white;
    logic signed [SUM_W-1:0]   w_sum, w_diff;
    logic signed [ERR_W-1:0]   w_err, w_s7;

    always_comb begin
        w_in_rd   = r_s1_bank ? w_rdata1 : w_rdata0;
        w_nx_rd   = r_s1_bank ? w_rdata0 : w_rdata1;
        // one-pixel rows: entry 0 is still held in the accumulator
        w_fwd     = (r_s1_col == '0) && (r_last == '0) && !r_s2_v;
        w_carried = w_fwd ? r_acc : (r_s1_filled ? w_in_rd : '0);
        w_old     = w_fwd ? '0    : (r_s1_filled ? w_nx_rd : '0);
        w_sum     = $signed({6'd0, r_s1_level, 4'd0}) + SUM_W'(w_carried) + SUM_W'(r_rc);
        w_white   = w_sum > HALF_LEVEL;
        w_diff    = w_sum - (w_white ? WHITE_LEVEL : '0);
        w_err     = f_sat16(WIDE_W'(w_diff));
        w_s7      = f_share(w_err, SHARE_RIGHT);
    end

    logic                      w_below, w_head;
    logic signed [ERR_W-1:0]   w_s1, w_s3, w_s5, w_a, w_acc_new, w_fin;
    logic [ERR_W-1:0]          w_own_data, w_other_data;

    always_comb begin
        w_below   = !r_s2_last_row;
        w_s1      = (w_below && !r_s2_last_col) ? f_share(r_s2_err, SHARE_BELOW_RIGHT) : '0;
        w_s3      = w_below ? f_share(r_s2_err, SHARE_BELOW_LEFT) : '0;
        w_s5      = w_below ? f_share(r_s2_err, SHARE_BELOW) : '0;
        w_a       = f_sat16(WIDE_W'(r_s2_old) + WIDE_W'(r_b1));
        w_acc_new = f_sat16(WIDE_W'(w_a) + WIDE_W'(w_s5));
        w_fin     = f_sat16(WIDE_W'(r_acc) + WIDE_W'(w_s3));
        // row start retires the previous row's last entry, else entry col-1
        w_head       = (r_s2_col == '0);
        w_wr_addr    = w_head ? r_last : r_s2_col - 1'b1;
        w_own_data   = w_head ? r_acc : '0;
        w_other_data = w_head ? '0 : w_fin;
        w_wdata0     = r_s2_bank ? w_other_data : w_own_data;
        w_wdata1     = r_s2_bank ? w_own_data : w_other_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_rc   <= '0;
            r_fill <= '0;
            r_acc  <= '0;
            r_b1   <= '0;
            r_last <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_bank <= n_bank;
            if (w_adv) begin
                r_s1_v <= w_accept;
                r_s2_v <= r_s1_v;
                if (r_s1_v) begin
                    r_rc <= r_s1_last_col ? '0 : w_s7;
                end
            end
            if (w_wr) begin
                if (FILL_W'(w_wr_addr) == r_fill) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_acc  <= w_acc_new;
                r_b1   <= w_s1;
                r_last <= r_s2_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_level    <= i_pixel_level;
            r_s1_col      <= r_col;
            r_s1_bank     <= r_bank;
            r_s1_last_col <= w_last_col;
            r_s1_last_row <= w_last_row;
            r_s1_filled   <= w_filled;
        end
        if (w_adv && r_s1_v) begin
            r_s2_white    <= w_white;
            r_s2_err      <= w_err;
            r_s2_old      <= w_old;
            r_s2_col      <= r_s1_col;
            r_s2_bank     <= r_s1_bank;
            r_s2_last_col <= r_s1_last_col;
            r_s2_last_row <= r_s1_last_row;
        end
    end

    assign o_valid     = r_s2_v;
    assign o_dot       = r_s2_white;
    assign o_row_end   = r_s2_last_col;
    assign o_frame_end = r_s2_last_col && r_s2_last_row;

endmodule
